// ===== src/omd_pkg.sv =====
// Shared types and constants for the OSC message decoder.
package omd_pkg;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_ADDR_BYTE  = 3'd0,
        KIND_ADDR_END   = 3'd1,
        KIND_INT        = 3'd2,
        KIND_FLOAT      = 3'd3,
        KIND_STR_BYTE   = 3'd4,
        KIND_STR_END    = 3'd5,
        KIND_VERDICT    = 3'd6
    } kind_t;

    // Verdict codes
    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_NO_SLASH   = 3'd1,
        STAT_NO_COMMA   = 3'd2,
        STAT_BAD_TAG    = 3'd3,
        STAT_TRUNCATED  = 3'd4,
        STAT_TOO_MANY   = 3'd5
    } status_t;

    // Stored argument type tags
    typedef enum logic [1:0] {
        TAG_INT   = 2'd0,
        TAG_FLOAT = 2'd1,
        TAG_STR   = 2'd2
    } tag_t;

    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_I     = 8'h69;
    localparam logic [7:0] CHAR_F     = 8'h66;
    localparam logic [7:0] CHAR_S     = 8'h73;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] field_value;
        logic [3:0]  arg_number;
        status_t     status;
        logic        end_of_message;
    } result_t;

    function automatic result_t make_result(kind_t k, logic [31:0] v, logic [3:0] a,
                                            status_t s, logic e);
        result_t r;
        r.kind           = k;
        r.field_value    = v;
        r.arg_number     = a;
        r.status         = s;
        r.end_of_message = e;
        return r;
    endfunction

endpackage

// ===== src/osc_message_decoder.sv =====
// OSC message decoder: one packet byte in per transfer, parsed fields out.
//
// Takes an OSC packet one byte per transfer, the last byte flagged by
// s_final_byte. The address bytes come out first (kind 0) followed by an
// address-end marker (kind 1); then each argument in type-tag order: a full
// big-endian int32 (kind 2) or float32 bit pattern (kind 3) on the fourth byte
// of its word, or string bytes (kind 4) and a string-end marker (kind 5).
// Strings are padded to 4-byte boundaries and padding is skipped unchecked.
// Every packet is closed by exactly one verdict (kind 6, end_of_message=1):
// ok, no leading '/', no ',', unknown tag, truncated, or more than MAX_ARGS
// tags. Bytes after a verdict produce nothing until the final byte, which
// rearms the parser. On a bad verdict the consumer drops what it received.
// Rate: one byte per cycle while s_ready is high. Each byte is parsed in the
// cycle it is accepted and yields zero, one or two results, written into a
// 4-entry result queue that drains one result per cycle while m_ready is high;
// s_ready is high while the queue has room for two, so two-result bytes can fill it.
// Argument tags sit in a MAX_ARGS-deep tag memory with a registered read that
// is steered by the next argument index, so the tag is ready when needed.
module osc_message_decoder #(
    parameter int MAX_ARGS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_packet_byte,
    input  logic              s_final_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output omd_pkg::kind_t    m_kind,
    output logic [31:0]       m_field_value,
    output logic [3:0]        m_arg_number,
    output omd_pkg::status_t  m_status,
    output logic              m_end_of_message
);
    import omd_pkg::*;

    // counters hold 0..MAX_ARGS, tag memory index holds 0..MAX_ARGS-1
    localparam int CNT_W = $clog2(MAX_ARGS + 1);
    localparam int IDX_W = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ARGS);

    typedef enum logic [1:0] {
        PH_ADDR,
        PH_TAGS,
        PH_ARGS,
        PH_DONE
    } phase_t;

    // parser state
    phase_t            phase_reg,  phase_next;
    logic [1:0]        off_reg,    off_next;     // byte offset within 4-byte word
    logic              first_reg,  first_next;   // next byte opens a string
    logic              pad_reg,    pad_next;     // skipping string padding
    logic [23:0]       acc_reg,    acc_next;     // first three bytes of a word
    logic [CNT_W-1:0]  total_reg,  total_next;   // tags stored
    logic [CNT_W-1:0]  cur_reg,    cur_next;     // argument being streamed

    // tag memory
    tag_t              tag_mem [MAX_ARGS];
    tag_t              tag_q_reg;                // tag_mem[cur_reg]
    logic              tag_we;
    tag_t              tag_wdata;

    // result queue
    result_t           fifo_reg [4];
    logic [1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [2:0]        count_reg,  count_next;
    result_t           res_next [2];
    logic [1:0]        n_res;

    logic              accept;
    logic              pop;
    logic [1:0]        off_inc;
    logic [CNT_W-1:0]  cur_inc;
    logic [CNT_W+3:0]  arg_wide;
    logic [3:0]        arg_num;
    result_t           head;

    assign s_ready  = (count_reg <= 3'd2);
    assign accept   = s_valid && s_ready;
    assign m_valid  = (count_reg != 3'd0);
    assign pop      = m_valid && m_ready;

    assign off_inc  = off_reg + 2'd1;
    assign cur_inc  = cur_reg + CNT_W'(1);
    assign arg_wide = {4'b0000, cur_reg};
    assign arg_num  = arg_wide[3:0];

    assign head             = fifo_reg[rd_ptr_reg];
    assign m_kind           = head.kind;
    assign m_field_value    = head.field_value;
    assign m_arg_number     = head.arg_number;
    assign m_status         = head.status;
    assign m_end_of_message = head.end_of_message;

    // Parse one byte: next state plus up to two results, in order.
    always_comb begin
        phase_next = phase_reg;
        off_next   = off_reg;
        first_next = first_reg;
        pad_next   = pad_reg;
        acc_next   = acc_reg;
        total_next = total_reg;
        cur_next   = cur_reg;
        tag_we     = 1'b0;
        tag_wdata  = TAG_INT;
        n_res      = 2'd0;
        res_next[0] = make_result(KIND_ADDR_BYTE, 32'd0, 4'd0, STAT_OK, 1'b0);
        res_next[1] = make_result(KIND_ADDR_BYTE, 32'd0, 4'd0, STAT_OK, 1'b0);

        if (accept) begin
            case (phase_reg)
                PH_ADDR: begin
                    if (pad_reg) begin
                        off_next = off_inc;
                        if (off_inc == 2'd0) begin
                            pad_next   = 1'b0;
                            first_next = 1'b1;
                            phase_next = PH_TAGS;
                        end
                    end else if (first_reg && s_packet_byte != CHAR_SLASH) begin
                        res_next[n_res[0]] = make_result(KIND_VERDICT, 32'd0, 4'd0,
                                                         STAT_NO_SLASH, 1'b1);
                        n_res      = n_res + 2'd1;
                        phase_next = PH_DONE;
                    end else begin
                        first_next = 1'b0;
                        off_next   = off_inc;
                        if (s_packet_byte != CHAR_NUL) begin
                            res_next[n_res[0]] = make_result(KIND_ADDR_BYTE,
                                {24'd0, s_packet_byte}, 4'd0, STAT_OK, 1'b0);
                            n_res = n_res + 2'd1;
                        end else begin
                            res_next[n_res[0]] = make_result(KIND_ADDR_END, 32'd0, 4'd0,
                                                             STAT_OK, 1'b0);
                            n_res = n_res + 2'd1;
                            if (off_inc == 2'd0) begin
                                first_next = 1'b1;
                                phase_next = PH_TAGS;
                            end else begin
                                pad_next = 1'b1;
                            end
                        end
                    end
                end

                PH_TAGS: begin
                    logic enter;
                    enter = 1'b0;
                    if (pad_reg) begin
                        off_next = off_inc;
                        enter    = (off_inc == 2'd0);
                    end else if (first_reg) begin
                        if (s_packet_byte != CHAR_COMMA) begin
                            res_next[n_res[0]] = make_result(KIND_VERDICT, 32'd0, 4'd0,
                                                             STAT_NO_COMMA, 1'b1);
                            n_res      = n_res + 2'd1;
                            phase_next = PH_DONE;
                        end else begin
                            first_next = 1'b0;
                            off_next   = off_inc;
                        end
                    end else begin
                        off_next = off_inc;
                        if (s_packet_byte == CHAR_NUL) begin
                            if (off_inc == 2'd0) begin
                                enter = 1'b1;
                            end else begin
                                pad_next = 1'b1;
                            end
                        end else begin
                            logic known;
                            known = 1'b1;
                            case (s_packet_byte)
                                CHAR_I:  tag_wdata = TAG_INT;
                                CHAR_F:  tag_wdata = TAG_FLOAT;
                                CHAR_S:  tag_wdata = TAG_STR;
                                default: known = 1'b0;
                            endcase
                            if (!known) begin
                                res_next[n_res[0]] = make_result(KIND_VERDICT, 32'd0,
                                    4'd0, STAT_BAD_TAG, 1'b1);
                                n_res      = n_res + 2'd1;
                                phase_next = PH_DONE;
                            end else if (total_reg >= MAX_CNT) begin
                                res_next[n_res[0]] = make_result(KIND_VERDICT, 32'd0,
                                    4'd0, STAT_TOO_MANY, 1'b1);
                                n_res      = n_res + 2'd1;
                                phase_next = PH_DONE;
                            end else begin
                                tag_we     = 1'b1;
                                total_next = total_reg + CNT_W'(1);
                            end
                        end
                    end
                    if (enter) begin
                        pad_next   = 1'b0;
                        off_next   = 2'd0;
                        first_next = 1'b1;
                        cur_next   = '0;
                        acc_next   = 24'd0;
                        phase_next = PH_ARGS;
                        if (total_reg == '0) begin
                            res_next[n_res[0]] = make_result(KIND_VERDICT, 32'd0, 4'd0,
                                                             STAT_OK, 1'b1);
                            n_res      = n_res + 2'd1;
                            phase_next = PH_DONE;
                        end
                    end
                end

                PH_ARGS: begin
                    logic advance;
                    advance  = 1'b0;
                    off_next = off_inc;
                    if (tag_q_reg == TAG_INT || tag_q_reg == TAG_FLOAT) begin
                        if (off_inc != 2'd0) begin
                            acc_next = {acc_reg[15:0], s_packet_byte};
                        end else begin
                            res_next[n_res[0]] = make_result(
                                (tag_q_reg == TAG_FLOAT) ? KIND_FLOAT : KIND_INT,
                                {acc_reg, s_packet_byte}, arg_num, STAT_OK, 1'b0);
                            n_res   = n_res + 2'd1;
                            advance = 1'b1;
                        end
                    end else if (pad_reg) begin
                        advance = (off_inc == 2'd0);
                    end else if (s_packet_byte != CHAR_NUL) begin
                        res_next[n_res[0]] = make_result(KIND_STR_BYTE,
                            {24'd0, s_packet_byte}, arg_num, STAT_OK, 1'b0);
                        n_res = n_res + 2'd1;
                    end else begin
                        res_next[n_res[0]] = make_result(KIND_STR_END, 32'd0, arg_num,
                                                         STAT_OK, 1'b0);
                        n_res = n_res + 2'd1;
                        if (off_inc == 2'd0) begin
                            advance = 1'b1;
                        end else begin
                            pad_next = 1'b1;
                        end
                    end
                    if (advance) begin
                        pad_next = 1'b0;
                        off_next = 2'd0;
                        acc_next = 24'd0;
                        cur_next = cur_inc;
                        if (cur_inc >= total_reg) begin
                            res_next[n_res[0]] = make_result(KIND_VERDICT, 32'd0, 4'd0,
                                                             STAT_OK, 1'b1);
                            n_res      = n_res + 2'd1;
                            phase_next = PH_DONE;
                        end
                    end
                end

                default: ;  // verdict given, ignore until final byte
            endcase

            // last byte: truncated unless already judged, then rearm
            if (s_final_byte) begin
                if (phase_next != PH_DONE) begin
                    res_next[n_res[0]] = make_result(KIND_VERDICT, 32'd0, 4'd0,
                                                     STAT_TRUNCATED, 1'b1);
                    n_res = n_res + 2'd1;
                end
                phase_next = PH_ADDR;
                off_next   = 2'd0;
                first_next = 1'b1;
                pad_next   = 1'b0;
                acc_next   = 24'd0;
                total_next = '0;
                cur_next   = '0;
            end
        end
    end

    assign count_next = count_reg + {1'b0, n_res} - {2'b00, pop};

    // parser state and queue control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_ADDR;
            off_reg    <= 2'd0;
            first_reg  <= 1'b1;
            pad_reg    <= 1'b0;
            acc_reg    <= 24'd0;
            total_reg  <= '0;
            cur_reg    <= '0;
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            phase_reg  <= phase_next;
            off_reg    <= off_next;
            first_reg  <= first_next;
            pad_reg    <= pad_next;
            acc_reg    <= acc_next;
            total_reg  <= total_next;
            cur_reg    <= cur_next;
            wr_ptr_reg <= wr_ptr_reg + n_res;
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg  <= count_next;
        end
    end

    // result queue payload
    always_ff @(posedge aclk) begin
        if (n_res != 2'd0) begin
            fifo_reg[wr_ptr_reg] <= res_next[0];
        end
        if (n_res == 2'd2) begin
            fifo_reg[wr_ptr_reg + 2'd1] <= res_next[1];
        end
    end

    // tag memory: write on tag byte, registered read at the next argument index
    always_ff @(posedge aclk) begin
        if (tag_we) begin
            tag_mem[total_reg[IDX_W-1:0]] <= tag_wdata;
        end
        if (cur_next < MAX_CNT) begin
            tag_q_reg <= tag_mem[cur_next[IDX_W-1:0]];
        end
    end

endmodule
